// File: rtl/fwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwt_pkg
// Constants, word table and match helpers for the function word tokenizer.
// ----------------------------------------------------------------------------
package fwt_pkg;

	localparam int NUM_REF_WORDS    = 63;
	localparam int MAX_KEPT_LETTERS = 6;

	localparam int TABLE_ENTRIES = 63;
	localparam int ABBREV_COUNT  = 7;
	localparam int ENTRY_CHARS   = 7;
	localparam int STR_W         = 8 * ENTRY_CHARS;
	localparam int LETTER_W      = 5;
	localparam int WORD_W        = LETTER_W * MAX_KEPT_LETTERS;
	localparam int LEN_W         = $clog2(MAX_KEPT_LETTERS + 2);
	localparam int WIDX_W        = $clog2(MAX_KEPT_LETTERS);
	localparam int ENTRY_LEN_W   = 3;
	localparam int INDEX_W       = 6;
	localparam int OUT_W         = 16;

	localparam logic [LEN_W-1:0]    LEN_MAX     = LEN_W'(MAX_KEPT_LETTERS);
	localparam logic [LEN_W-1:0]    LEN_TOOLONG = LEN_W'(MAX_KEPT_LETTERS + 1);
	localparam logic [LETTER_W-1:0] LETTER_V    = 5'd21;

	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_DASH    = 8'h2D;

	typedef struct packed {
		logic [ENTRY_LEN_W-1:0] len;
		logic [WORD_W-1:0]      letters;
	} ref_entry_t;

	function automatic logic [STR_W-1:0] ref_word(input logic [INDEX_W-1:0] idx);
		unique case (idx)
			6'd0:  return "A";
			6'd1:  return "ALL";
			6'd2:  return "ALSO";
			6'd3:  return "AN";
			6'd4:  return "AND";
			6'd5:  return "ANY";
			6'd6:  return "ARE";
			6'd7:  return "AS";
			6'd8:  return "AT";
			6'd9:  return "BE";
			6'd10: return "BEEN";
			6'd11: return "BUT";
			6'd12: return "BY";
			6'd13: return "CAN";
			6'd14: return "DO";
			6'd15: return "DOWN";
			6'd16: return "EVEN";
			6'd17: return "FOR";
			6'd18: return "FROM";
			6'd19: return "HAD";
			6'd20: return "HAS";
			6'd21: return "HAVE";
			6'd22: return "HER";
			6'd23: return "HIS";
			6'd24: return "IF";
			6'd25: return "IN";
			6'd26: return "INTO";
			6'd27: return "IS";
			6'd28: return "IT";
			6'd29: return "ITS";
			6'd30: return "MAY";
			6'd31: return "MORE";
			6'd32: return "MUST";
			6'd33: return "NO";
			6'd34: return "NOT";
			6'd35: return "NOW";
			6'd36: return "OF";
			6'd37: return "ON";
			6'd38: return "ONE";
			6'd39: return "ONLY";
			6'd40: return "OR";
			6'd41: return "OUR";
			6'd42: return "SO";
			6'd43: return "SOME";
			6'd44: return "SUCH";
			6'd45: return "THAN";
			6'd46: return "THAT";
			6'd47: return "THE";
			6'd48: return "THEIR";
			6'd49: return "THEN";
			6'd50: return "THERE";
			6'd51: return "THINGS";
			6'd52: return "THIS";
			6'd53: return "TO";
			6'd54: return "UP";
			6'd55: return "WAS";
			6'd56: return "WERE";
			6'd57: return "WHAT";
			6'd58: return "WHEN";
			6'd59: return "WHICH";
			6'd60: return "WHO";
			6'd61: return "WITH";
			6'd62: return "WOULD";
			default: return '0;
		endcase
	endfunction

	// Words after which a period does not close a sentence.
	function automatic logic [STR_W-1:0] abbrev_word(input logic [2:0] idx);
		unique case (idx)
			3'd0: return "DR";
			3'd1: return "RD";
			3'd2: return "ST";
			3'd3: return "MR";
			3'd4: return "MS";
			3'd5: return "MRS";
			3'd6: return "PROF";
			default: return '0;
		endcase
	endfunction

	// String literals are right-justified, so the first character sits in
	// the highest nonzero byte.
	function automatic ref_entry_t make_entry(input logic [STR_W-1:0] s);
		ref_entry_t e;
		int         n;
		e = '0;
		n = 0;
		for (int b = 0; b < ENTRY_CHARS; b++) begin
			if (s[8*b +: 8] != 8'h00) begin
				n = b + 1;
			end
		end
		e.len = ENTRY_LEN_W'(n);
		for (int i = 0; i < MAX_KEPT_LETTERS; i++) begin
			if (i < n) begin
				e.letters[i*LETTER_W +: LETTER_W] = s[8*(n-1-i) +: LETTER_W] - 5'd1;
			end
		end
		return e;
	endfunction

	function automatic logic word_matches(input logic [WORD_W-1:0] w,
	                                      input logic [LEN_W-1:0]  len,
	                                      input ref_entry_t        e);
		logic m;
		m = (int'(len) == int'(e.len)) && (int'(len) <= MAX_KEPT_LETTERS);
		for (int p = 0; p < MAX_KEPT_LETTERS; p++) begin
			if (p < int'(len) &&
			    w[p*LETTER_W +: LETTER_W] != e.letters[p*LETTER_W +: LETTER_W]) begin
				m = 1'b0;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// File: rtl/function_word_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// function_word_tokenizer_core
// Byte stream word tokenizer with function word lookup and sentence marking.
// ----------------------------------------------------------------------------
// One text byte enters per item and one result item leaves per byte. The
// block takes a new byte every cycle: a byte is registered, then the word
// state update and the parallel compare against the word table run
// combinationally into the output register, so the sustained rate is one
// item per cycle while the output side keeps up. Letters are folded to
// upper case and at most six are kept; longer words match nothing. The
// current word and the dash flag are cleared by the start-of-text flag
// before its byte is handled.
module function_word_tokenizer_core
	import fwt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [7:0]       s_tdata,   // [7:0] text_byte
	input  wire logic             s_tuser,   // [0] start_of_text
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata    // [0] word_end, [1] is_reference,
	                                         // [7:2] ref_index, [8] sentence_end,
	                                         // [9] v_abbreviation, [15:10] zero
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                sot_s1;
	logic                valid_s2;
	logic [OUT_W-1:0]    data_s2;

	logic [WORD_W-1:0]   letters_q;
	logic [LEN_W-1:0]    word_len_q;
	logic                dash_q;

	logic                advance;
	logic [LEN_W-1:0]    len_eff;
	logic                dash_eff;
	logic                is_letter;
	logic [LETTER_W-1:0] code;
	logic                is_ender;
	logic                word_end;
	logic                vab;
	logic                sent_end;
	logic [TABLE_ENTRIES-1:0] ref_hit;
	logic [ABBREV_COUNT-1:0]  abbrev_hit;
	logic                is_ref;
	logic [INDEX_W-1:0]  ref_idx;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			sot_s1  <= s_tuser;
		end
	end

	always_comb begin
		len_eff   = sot_s1 ? '0 : word_len_q;
		dash_eff  = sot_s1 ? 1'b0 : dash_q;
		is_letter = (byte_s1 >= 8'h41 && byte_s1 <= 8'h5A) ||
		            (byte_s1 >= 8'h61 && byte_s1 <= 8'h7A);
		// Upper and lower case letters share their low five bits.
		code      = byte_s1[4:0] - 5'd1;
		is_ender  = byte_s1 == CH_BANG || byte_s1 == CH_QUEST ||
		            byte_s1 == CH_SPACE || byte_s1 == CH_DOT ||
		            byte_s1 == CH_NEWLINE || (dash_eff && byte_s1 == CH_DASH);
		word_end  = !is_letter && is_ender && len_eff != '0;
		vab       = byte_s1 == CH_DOT && len_eff == LEN_W'(1) &&
		            letters_q[LETTER_W-1:0] == LETTER_V;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_ref
		localparam ref_entry_t ENTRY = make_entry(ref_word(INDEX_W'(i)));
		assign ref_hit[i] = (i < NUM_REF_WORDS) && word_matches(letters_q, len_eff, ENTRY);
	end

	for (genvar i = 0; i < ABBREV_COUNT; i++) begin : g_abbrev
		localparam ref_entry_t ENTRY = make_entry(abbrev_word(3'(i)));
		assign abbrev_hit[i] = word_matches(letters_q, len_eff, ENTRY);
	end

	// Table words are distinct, so at most one entry hits and an OR of the
	// hit indexes is the index itself.
	always_comb begin
		ref_idx = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (ref_hit[i]) begin
				ref_idx = ref_idx | INDEX_W'(i);
			end
		end
		is_ref   = word_end && (|ref_hit);
		sent_end = word_end && (byte_s1 == CH_BANG || byte_s1 == CH_QUEST ||
		                        (byte_s1 == CH_DOT && !(|abbrev_hit)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q <= '0;
			dash_q     <= 1'b0;
		end else if (advance) begin
			dash_q <= byte_s1 == CH_DASH;
			if (is_letter) begin
				word_len_q <= (len_eff < LEN_MAX) ? len_eff + LEN_W'(1) : LEN_TOOLONG;
			end else if (word_end) begin
				word_len_q <= '0;
			end else begin
				word_len_q <= len_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_letter && len_eff < LEN_MAX) begin
			for (int k = 0; k < MAX_KEPT_LETTERS; k++) begin
				if (len_eff[WIDX_W-1:0] == WIDX_W'(k)) begin
					letters_q[k*LETTER_W +: LETTER_W] <= code;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {6'b0, vab, sent_end, (is_ref ? ref_idx : 6'b0), is_ref, word_end};
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_len_q <= LEN_TOOLONG)
		else $error("word length beyond saturation value");

	a_ref_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[1] && !m_tdata[8]) || m_tdata[0])
		else $error("match or sentence end without a word end");

	a_letter_len: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_letter |=> word_len_q != '0)
		else $error("letter did not extend the word");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_end |=> word_len_q == '0)
		else $error("word end did not clear the word");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[7:2] == 6'b0)
		else $error("nonzero index without a match");

endmodule
`default_nettype wire
